[rtl/vdfs_pkg.sv]
// Shared constants, codes and control/status types for the voxel distance fusion store.
package vdfs_pkg;

  localparam int unsigned VOXELS_DEF     = 4096;
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned INDEX_BITS     = 12;
  localparam int unsigned CFG_IDX_BITS   = 3;

  // background variance, 100.0 in Q8.8
  localparam int unsigned VAR_BG    = 25600;
  localparam int unsigned TRUNC_RST = 77;
  localparam int unsigned FLOOR_RST = 25600;

  localparam logic [1:0] CMD_FUSE  = 2'd0;
  localparam logic [1:0] CMD_SWEEP = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_TRUNC  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VPEN   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DPEN   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRUNE  = 3'd4;

  typedef enum logic [1:0] {
    RES_EVAL  = 2'd0,
    RES_FIN   = 2'd1,
    RES_SWEEP = 2'd2
  } vdfs_res_e;

  typedef struct packed {
    logic      addr_ld;
    logic      addr_clr;
    logic      addr_inc;
    logic      mem_clear;
    logic      mem_sweep;
    logic      mem_fuse;
    logic      in_ld;
    logic      prep_ld;
    logic      mul1;
    logic      mul2;
    logic      div_start;
    logic      div_dist;
    logic      qv_ld;
    logic      res_ld;
    vdfs_res_e res_sel;
    logic      out_ld;
  } vdfs_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       fuse_skip;
    logic       addr_last;
    logic       div_done;
  } vdfs_stat_t;

endpackage

[rtl/vdfs_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module vdfs_div #(
  parameter int unsigned NW = 33,
  parameter int unsigned DW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] dvd_q, quo_q;
  logic [DW-1:0] dsr_q, rem_q;
  logic [DW:0]   trial;
  logic          qbit;

  assign trial = {rem_q, dvd_q[NW-1]};
  assign qbit  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[NW-2:0], qbit};
      rem_q <= qbit ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/vdfs_datapath.sv]
// Datapath: configuration registers, voxel memory, fuse arithmetic, sweep update, result registers.
module vdfs_datapath #(
  parameter int unsigned VOXELS     = vdfs_pkg::VOXELS_DEF,
  parameter int unsigned VALUE_BITS = vdfs_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vdfs_pkg::vdfs_cmd_t               cmd_i,
  output vdfs_pkg::vdfs_stat_t              stat_o,
  input  logic [1:0]                        command_i,
  input  logic [vdfs_pkg::INDEX_BITS-1:0]   voxel_index_i,
  input  logic signed [VALUE_BITS-1:0]      obs_distance_i,
  input  logic [VALUE_BITS-1:0]             obs_variance_i,
  input  logic                              cfg_we_i,
  input  logic [vdfs_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [VALUE_BITS-1:0]             cfg_data_i,
  output logic signed [VALUE_BITS-1:0]      distance_out_o,
  output logic [VALUE_BITS-1:0]             variance_out_o,
  output logic                              active_out_o,
  output logic                              applied_o,
  output logic                              kept_o
);

  localparam int unsigned W  = VALUE_BITS;
  localparam int unsigned AW = $clog2(VOXELS);
  localparam int unsigned MW = 2 * W + 3;  // {touched, active, updated, dist, var}
  localparam int unsigned NW = 2 * W + 1;
  localparam int unsigned DW = W + 1;

  localparam logic signed [W-1:0] DMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] DMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]        VMAX = '1;
  localparam logic [W-1:0]        VBG  = W'(vdfs_pkg::VAR_BG);

  // configuration
  logic [W-2:0] trunc_q, dpen_q;
  logic [W-1:0] floor_q, vpen_q, prune_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_q <= (W-1)'(vdfs_pkg::TRUNC_RST);
      floor_q <= W'(vdfs_pkg::FLOOR_RST);
      vpen_q  <= '0;
      dpen_q  <= '0;
      prune_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vdfs_pkg::REG_TRUNC: trunc_q <= cfg_data_i[W-2:0];
        vdfs_pkg::REG_FLOOR: floor_q <= cfg_data_i;
        vdfs_pkg::REG_VPEN:  vpen_q  <= cfg_data_i;
        vdfs_pkg::REG_DPEN:  dpen_q  <= cfg_data_i[W-2:0];
        vdfs_pkg::REG_PRUNE: prune_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]          cmd_q;
  logic signed [W-1:0] od_q;
  logic [W-1:0]        ov_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ld) begin
      cmd_q <= command_i;
      od_q  <= obs_distance_i;
      ov_q  <= obs_variance_i;
    end
  end

  // address
  logic [AW-1:0] addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.addr_clr) begin
      addr_q <= '0;
    end else if (cmd_i.addr_ld) begin
      addr_q <= AW'(voxel_index_i);
    end else if (cmd_i.addr_inc) begin
      addr_q <= addr_q + 1'b1;
    end
  end

  // voxel memory
  logic [MW-1:0] mem [VOXELS];
  logic [MW-1:0] rdata_q, wdata;
  logic          we;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr_q] <= wdata;
    end
    rdata_q <= mem[addr_q];
  end

  logic                r_t, r_a, r_u;
  logic signed [W-1:0] r_dist;
  logic [W-1:0]        r_var;
  logic signed [W-1:0] tr_s, pd, odc;
  logic [W-1:0]        pv;

  assign {r_t, r_a, r_u} = rdata_q[MW-1 -: 3];
  assign r_dist = rdata_q[2*W-1 -: W];
  assign r_var  = rdata_q[W-1:0];
  assign tr_s   = {1'b0, trunc_q};
  assign pd     = r_t ? r_dist : tr_s;
  assign pv     = r_t ? r_var : VBG;
  assign odc    = (od_q > tr_s) ? tr_s : od_q;

  // fuse operands and products
  logic signed [W-1:0] pd_q, odc_q;
  logic [W-1:0]        pv_q;
  logic [W:0]          sum_q;
  logic signed [2*W:0] p1_q, p2_q;
  logic signed [2*W+1:0] num_q;
  logic [2*W-1:0]      pvov_q;
  logic [NW-1:0]       qv_q, quot, dividend;
  logic                div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep_ld) begin
      pd_q  <= pd;
      pv_q  <= pv;
      odc_q <= odc;
      sum_q <= {1'b0, pv} + {1'b0, ov_q};
    end
    if (cmd_i.mul1) begin
      p1_q <= $signed({1'b0, ov_q}) * pd_q;
      p2_q <= $signed({1'b0, pv_q}) * odc_q;
    end
    if (cmd_i.mul2) begin
      num_q  <= (2*W+2)'(p1_q) + (2*W+2)'(p2_q);
      pvov_q <= pv_q * ov_q;
    end
    if (cmd_i.qv_ld) begin
      qv_q <= quot;
    end
  end

  logic [2*W+1:0] num_abs;
  assign num_abs  = num_q[2*W+1] ? (2*W+2)'(-num_q) : num_q;
  assign dividend = cmd_i.div_dist ? num_abs[NW-1:0] : NW'(pvov_q);

  vdfs_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dividend),
    .divisor_i (sum_q),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  // fuse finish: sign, saturate, floor
  logic signed [W-1:0] nd_fin;
  logic [W-1:0]        nv_fin, nv_raw;

  always_comb begin
    if (num_q[2*W+1]) begin
      nd_fin = (quot > NW'({1'b1, {(W-1){1'b0}}})) ? DMIN : W'(-quot);
    end else begin
      nd_fin = (quot > NW'(DMAX)) ? DMAX : W'(quot);
    end
    nv_raw = (qv_q > NW'(VMAX)) ? VMAX : W'(qv_q);
    if (sum_q == '0) begin
      nd_fin = odc_q;
      nv_raw = '0;
    end
    nv_fin = (nv_raw < floor_q) ? floor_q : nv_raw;
  end

  // sweep update
  logic signed [W:0]   dsum;
  logic signed [W-1:0] dsat, sw_dist;
  logic [W:0]          vsum;
  logic [W-1:0]        vsat, sw_var;
  logic                sw_act;

  always_comb begin
    dsum   = (W+1)'(r_dist) + $signed({2'b00, dpen_q});
    dsat   = (dsum > (W+1)'(DMAX)) ? DMAX : W'(dsum);
    sw_dist = r_dist;
    sw_act  = r_a;
    if (!r_u) begin
      if (dsat > tr_s) sw_act = 1'b0;
      else             sw_dist = dsat;
    end
    vsum   = {1'b0, r_var} + {1'b0, vpen_q};
    vsat   = vsum[W] ? VMAX : vsum[W-1:0];
    sw_var = r_var;
    if (32'(vsat) <= 32'(vdfs_pkg::VAR_BG)) begin
      sw_var = (vsat < floor_q) ? floor_q : vsat;
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    if (cmd_i.mem_clear) begin
      we = 1'b1;
    end else if (cmd_i.mem_sweep) begin
      we    = r_a;
      wdata = {r_t, sw_act, 1'b0, sw_dist, sw_var};
    end else if (cmd_i.mem_fuse) begin
      we    = 1'b1;
      wdata = {3'b111, nd_fin, nv_fin};
    end
  end

  // result
  logic signed [W-1:0] res_dist_q, res_dist;
  logic [W-1:0]        res_var_q, res_var;
  logic                res_act_q, res_app_q, res_kept_q, res_act, res_app, res_kept;
  logic                kept_rd;

  assign kept_rd = r_a && (pv > prune_q);

  always_comb begin
    res_dist = '0;
    res_var  = '0;
    res_act  = 1'b0;
    res_app  = 1'b0;
    res_kept = 1'b0;
    unique case (cmd_i.res_sel)
      vdfs_pkg::RES_EVAL: begin
        if (cmd_q == vdfs_pkg::CMD_FUSE) begin
          res_dist = pd;
          res_var  = pv;
          res_act  = r_a;
        end else if (cmd_q == vdfs_pkg::CMD_READ) begin
          res_dist = kept_rd ? pd : tr_s;
          res_var  = pv;
          res_act  = r_a;
          res_kept = kept_rd;
        end
      end
      vdfs_pkg::RES_FIN: begin
        res_dist = nd_fin;
        res_var  = nv_fin;
        res_act  = 1'b1;
        res_app  = 1'b1;
      end
      vdfs_pkg::RES_SWEEP: res_app = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      res_dist_q <= res_dist;
      res_var_q  <= res_var;
      res_act_q  <= res_act;
      res_app_q  <= res_app;
      res_kept_q <= res_kept;
    end
    if (cmd_i.out_ld) begin
      distance_out_o <= res_dist_q;
      variance_out_o <= res_var_q;
      active_out_o   <= res_act_q;
      applied_o      <= res_app_q;
      kept_o         <= res_kept_q;
    end
  end

  assign stat_o.command   = cmd_q;
  assign stat_o.fuse_skip = !(od_q > -tr_s);
  assign stat_o.addr_last = (addr_q == AW'(VOXELS - 1));
  assign stat_o.div_done  = div_done;

endmodule

[rtl/vdfs_ctrl.sv]
// Controller state machine: clearing pass, command sequencing, output handshake.
module vdfs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  vdfs_pkg::vdfs_stat_t stat_i,
  output vdfs_pkg::vdfs_cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    ST_CLEAR = 14'b00000000000001,
    ST_IDLE  = 14'b00000000000010,
    ST_READ  = 14'b00000000000100,
    ST_EVAL  = 14'b00000000001000,
    ST_MUL1  = 14'b00000000010000,
    ST_MUL2  = 14'b00000000100000,
    ST_DIVV  = 14'b00000001000000,
    ST_WAITV = 14'b00000010000000,
    ST_DIVD  = 14'b00000100000000,
    ST_WAITD = 14'b00001000000000,
    ST_FIN   = 14'b00010000000000,
    ST_SWRD  = 14'b00100000000000,
    ST_SWWR  = 14'b01000000000000,
    ST_EMIT  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = vdfs_pkg::RES_EVAL;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_clear = 1'b1;
        if (stat_i.addr_last) begin
          cmd_o.addr_clr = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.addr_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_ld   = 1'b1;
          cmd_o.addr_ld = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (stat_i.command == vdfs_pkg::CMD_SWEEP) begin
          cmd_o.addr_clr = 1'b1;
          state_d = ST_SWRD;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.command == vdfs_pkg::CMD_FUSE && !stat_i.fuse_skip) begin
          cmd_o.prep_ld = 1'b1;
          state_d = ST_MUL1;
        end else begin
          cmd_o.res_ld = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = ST_DIVV;
      end
      ST_DIVV: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_WAITV;
      end
      ST_WAITV: begin
        if (stat_i.div_done) begin
          cmd_o.qv_ld = 1'b1;
          state_d = ST_DIVD;
        end
      end
      ST_DIVD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_dist  = 1'b1;
        state_d = ST_WAITD;
      end
      ST_WAITD: begin
        if (stat_i.div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.mem_fuse = 1'b1;
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_sel  = vdfs_pkg::RES_FIN;
        state_d = ST_EMIT;
      end
      ST_SWRD: state_d = ST_SWWR;
      ST_SWWR: begin
        cmd_o.mem_sweep = 1'b1;
        if (stat_i.addr_last) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = vdfs_pkg::RES_SWEEP;
          state_d = ST_EMIT;
        end else begin
          cmd_o.addr_inc = 1'b1;
          state_d = ST_SWRD;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_ld = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld)      out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/voxel_distance_fusion_store.sv]
// Top level of the voxel distance fusion store: controller plus datapath.
//
// Input channel (in_valid_i / in_stall_o) carries one command per transfer:
// fuse an observation into a voxel, sweep all voxels, or read a voxel.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// command. The result sits in an output register, so the next command is
// taken while an earlier result still waits for its transfer.
// Steps from input transfer to result loaded in the output register:
//   read, a rejected fuse or an unknown command: memory read, evaluation;
//   applied fuse: operand preparation, multiply and sum steps, then two passes
//   through the divider, variance first and distance second, and the write;
//   sweep: one memory read per voxel and a write for each active voxel.
// One command is in work at a time; the next is accepted once the result is
// handed to the output register.
// Reset: configuration registers take their defaults, then a clearing pass
// over all VOXELS entries zeroes the voxel memory flags; input stalls meanwhile,
// configuration writes are taken at any time.
// A stalled result holds in the output register; a finished result behind it
// waits in the datapath result registers until the output register frees up.
module voxel_distance_fusion_store #(
  parameter int unsigned VOXELS     = vdfs_pkg::VOXELS_DEF,
  parameter int unsigned VALUE_BITS = vdfs_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        command_i,
  input  logic [vdfs_pkg::INDEX_BITS-1:0]   voxel_index_i,
  input  logic signed [VALUE_BITS-1:0]      obs_distance_i,
  input  logic [VALUE_BITS-1:0]             obs_variance_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [VALUE_BITS-1:0]      distance_out_o,
  output logic [VALUE_BITS-1:0]             variance_out_o,
  output logic                              active_out_o,
  output logic                              applied_o,
  output logic                              kept_o,
  input  logic                              cfg_we_i,
  input  logic [vdfs_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [VALUE_BITS-1:0]             cfg_data_i
);

  vdfs_pkg::vdfs_cmd_t  cmd;
  vdfs_pkg::vdfs_stat_t stat;

  // sequencing: clear pass, per-command steps, output register handshake
  vdfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // memory, fuse arithmetic, sweep update, config and result registers
  vdfs_datapath #(
    .VOXELS    (VOXELS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .command_i     (command_i),
    .voxel_index_i (voxel_index_i),
    .obs_distance_i(obs_distance_i),
    .obs_variance_i(obs_variance_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .distance_out_o(distance_out_o),
    .variance_out_o(variance_out_o),
    .active_out_o  (active_out_o),
    .applied_o     (applied_o),
    .kept_o        (kept_o)
  );

endmodule

[tb/sv/voxel_distance_fusion_store_tb.sv]
// Self-checking testbench for the voxel distance fusion store.
module voxel_distance_fusion_store_tb;
  import vdfs_pkg::*;

  localparam logic [1:0] CMD_NONE   = 2'd3;  // unused code, answers with all zero
  localparam int         CYCLE_CAP  = 3000000;
  localparam int         PHASES     = 9;
  localparam int         PHASE_ITEMS = 200;

  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] variance;
    logic        active;
    logic        applied;
    logic        kept;
  } voxel_result_t;

  // Scoreboard: keeps its own copy of the voxel store and predicts each result.
  class fusion_scoreboard;
    int            dist_mem[4096];
    int            varc_mem[4096];
    bit            touched[4096];
    bit            active[4096];
    bit            updated[4096];
    longint        trunc, vfloor, vpen, dpen, prune;
    voxel_result_t pending[$];
    int            errors;

    function new();
      trunc = TRUNC_RST; vfloor = FLOOR_RST; vpen = 0; dpen = 0; prune = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
      case (idx)
        REG_TRUNC: trunc  = val[14:0];
        REG_FLOOR: vfloor = val;
        REG_VPEN:  vpen   = val;
        REG_DPEN:  dpen   = val[14:0];
        REG_PRUNE: prune  = val;
        default: ;
      endcase
    endfunction

    function void note_input(logic [1:0] cmd, logic [11:0] idx, logic [15:0] od_raw,
                             logic [15:0] ov_raw);
      longint        od, ov, pd, pv, nd, nv, sum;
      voxel_result_t r;
      r  = '0;
      od = longint'($signed(od_raw));
      ov = longint'(ov_raw);
      pd = touched[idx] ? longint'(dist_mem[idx]) : trunc;
      pv = touched[idx] ? longint'(varc_mem[idx]) : longint'(VAR_BG);
      case (cmd)
        CMD_FUSE: begin
          if (!(od > -trunc)) begin
            // rejected: report current state untouched
            r.distance = pd[15:0]; r.variance = pv[15:0]; r.active = active[idx];
          end else begin
            if (od > trunc) od = trunc;
            sum = pv + ov;
            if (sum == 0) begin
              nd = od; nv = 0;
            end else begin
              nv = (pv * ov) / sum;
              nd = (ov * pd + pv * od) / sum;
            end
            if (nv < vfloor) nv = vfloor;
            if (nd > 32767) nd = 32767;
            if (nd < -32768) nd = -32768;
            if (nv > 65535) nv = 65535;
            dist_mem[idx] = int'(nd); varc_mem[idx] = int'(nv);
            touched[idx] = 1; active[idx] = 1; updated[idx] = 1;
            r.distance = nd[15:0]; r.variance = nv[15:0]; r.active = 1; r.applied = 1;
          end
        end
        CMD_SWEEP: begin
          for (int i = 0; i < 4096; i++) begin
            if (active[i]) begin
              if (!updated[i]) begin
                nd = longint'(dist_mem[i]) + dpen;
                if (nd > 32767) nd = 32767;
                if (nd > trunc) active[i] = 0;  // drifted past truncation: retire
                else dist_mem[i] = int'(nd);
              end else begin
                updated[i] = 0;
              end
              nv = longint'(varc_mem[i]) + vpen;
              if (nv > 65535) nv = 65535;
              if (nv <= VAR_BG) begin
                if (nv < vfloor) nv = vfloor;
                varc_mem[i] = int'(nv);
              end
            end
          end
          r.applied = 1;
        end
        CMD_READ: begin
          r.active   = active[idx];
          r.kept     = active[idx] && (pv > prune);
          r.distance = r.kept ? pd[15:0] : trunc[15:0];
          r.variance = pv[15:0];
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(voxel_result_t got);
      voxel_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp d=%h v=%h a=%b ap=%b k=%b, got d=%h v=%h a=%b ap=%b k=%b",
                   want.distance, want.variance, want.active, want.applied, want.kept,
                   got.distance, got.variance, got.active, got.applied, got.kept);
      end
    endfunction
  endclass

  logic                    clk_i = 0;
  logic                    rst_ni = 0;
  logic                    in_valid_i = 0;
  logic                    in_stall_o;
  logic [1:0]              command_i = '0;
  logic [INDEX_BITS-1:0]   voxel_index_i = '0;
  logic signed [15:0]      obs_distance_i = '0;
  logic [15:0]             obs_variance_i = 16'd1;
  logic                    out_valid_o;
  logic                    out_stall_i = 0;
  logic signed [15:0]      distance_out_o;
  logic [15:0]             variance_out_o;
  logic                    active_out_o, applied_o, kept_o;
  logic                    cfg_we_i = 0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [15:0]             cfg_data_i = '0;

  fusion_scoreboard sb = new();
  bit               calm = 0;     // no idling on either side in the closing phase
  int               cycles = 0;
  logic [11:0]      pool_base;

  voxel_distance_fusion_store dut (.*);

  always #10 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: every transfer goes to the scoreboard.
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({distance_out_o, variance_out_o, active_out_o, applied_o, kept_o});

  // Receiver back-pressure in bursts of random length.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall_i = 1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 0;
    end
  end

  // Drive one command and hold it until the transfer; inputs move on falling edges.
  task automatic send_cmd(logic [1:0] cmd, logic [11:0] idx, logic [15:0] od, logic [15:0] ov);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 4);
      in_valid_i = 0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i = 1; command_i = cmd; voxel_index_i = idx;
    obs_distance_i = od; obs_variance_i = ov;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_input(cmd, idx, od, ov);
    @(negedge clk_i);
  endtask

  // Park the input and wait until every predicted result has come back.
  task automatic drain();
    in_valid_i = 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
    cfg_we_i = 1; cfg_index_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.set_reg(idx, val);
  endtask

  task automatic random_cmd();
    int          r;
    logic [1:0]  cmd;
    logic [11:0] idx;
    longint      od;
    logic [15:0] ov;
    r   = $urandom_range(0, 99);
    cmd = (r < 55) ? CMD_FUSE : (r < 57) ? CMD_SWEEP : (r < 97) ? CMD_READ : CMD_NONE;
    // mostly a small working set so voxels get fused, swept and read repeatedly
    idx = ($urandom_range(0, 9) < 7) ? pool_base + 12'($urandom_range(0, 15)) : 12'($urandom);
    if ($urandom_range(0, 9) < 6) begin
      od = longint'($urandom_range(0, 4 * sb.trunc + 4)) - 2 * sb.trunc - 2;
      if (od > 32767) od = 32767;
      if (od < -32768) od = -32768;
    end else begin
      od = longint'($signed(16'($urandom)));
    end
    ov = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 65535))
                                     : 16'($urandom_range(1, 3000));
    send_cmd(cmd, idx, od[15:0], ov);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    pool_base = '0;

    // directed: untouched reads, boundaries of the acceptance window, extremes
    send_cmd(CMD_READ,  12'd0,    16'd0,      16'd1);
    send_cmd(CMD_FUSE,  12'd1,    -16'sd77,   16'd256);   // exactly at -trunc: rejected
    send_cmd(CMD_FUSE,  12'd1,    -16'sd76,   16'd256);   // just inside
    send_cmd(CMD_FUSE,  12'd2,    16'h7FFF,   16'd1);     // clamped to trunc
    send_cmd(CMD_FUSE,  12'd3,    16'h8000,   16'hFFFF);  // most negative: rejected
    send_cmd(CMD_FUSE,  12'hFFF,  16'd40,     16'hFFFF);
    send_cmd(CMD_FUSE,  12'd1,    16'd10,     16'd1);
    send_cmd(CMD_READ,  12'd1,    16'd0,      16'd1);
    send_cmd(CMD_READ,  12'hFFF,  16'hFFFF,   16'hFFFF);
    send_cmd(CMD_NONE,  12'hABC,  16'h5555,   16'hAAAA);
    send_cmd(CMD_SWEEP, 12'd0,    16'd0,      16'd1);     // updated voxels get cleared
    send_cmd(CMD_SWEEP, 12'd0,    16'd0,      16'd1);     // now they take the penalty
    send_cmd(CMD_READ,  12'd2,    16'd0,      16'd1);
    drain();
    write_reg(REG_DPEN, 16'd100);
    write_reg(REG_VPEN, 16'd4000);
    write_reg(REG_PRUNE, 16'd30000);
    send_cmd(CMD_SWEEP, 12'd0,    16'd0,      16'd1);     // distance runs past trunc: retire
    send_cmd(CMD_READ,  12'd1,    16'd0,      16'd1);
    send_cmd(CMD_READ,  12'hFFF,  16'd0,      16'd1);
    send_cmd(CMD_FUSE,  12'd5,    16'd30,     16'd100);
    send_cmd(CMD_READ,  12'd5,    16'd0,      16'd1);     // variance below prune: not kept

    for (int p = 0; p < PHASES; p++) begin
      drain();  // block is idle before any register change
      case (p)
        0: begin
          write_reg(REG_TRUNC, 16'd1); write_reg(REG_FLOOR, 16'd0);
          write_reg(REG_VPEN, 16'd0); write_reg(REG_DPEN, 16'd0);
          write_reg(REG_PRUNE, 16'd0);
        end
        1: begin
          write_reg(REG_TRUNC, 16'd32767); write_reg(REG_FLOOR, 16'd65535);
          write_reg(REG_VPEN, 16'd65535); write_reg(REG_DPEN, 16'd32767);
          write_reg(REG_PRUNE, 16'd65535);
        end
        2: begin
          write_reg(REG_TRUNC, 16'd512); write_reg(REG_FLOOR, 16'd0);
          write_reg(REG_VPEN, 16'd65535); write_reg(REG_DPEN, 16'd0);
          write_reg(REG_PRUNE, 16'd0);
        end
        3: begin
          write_reg(REG_TRUNC, 16'd32767); write_reg(REG_FLOOR, 16'd100);
          write_reg(REG_VPEN, 16'd300); write_reg(REG_DPEN, 16'd32767);
          write_reg(REG_PRUNE, 16'd200);
        end
        default: begin
          write_reg(REG_TRUNC, 16'($urandom_range(1, 32767)));
          write_reg(REG_FLOOR, 16'($urandom_range(0, 65535)));
          write_reg(REG_VPEN,  16'($urandom_range(0, 65535)));
          write_reg(REG_DPEN,  16'($urandom_range(0, 32767)));
          write_reg(REG_PRUNE, 16'($urandom_range(0, 65535)));
        end
      endcase
      calm = (p == PHASES - 1);
      pool_base = 12'($urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 5 && k == PHASE_ITEMS / 2) drain();  // sender holds off mid-phase
        random_cmd();
      end
    end

    in_valid_i = 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/vdfs_pkg.sv
rtl/vdfs_div.sv
rtl/vdfs_datapath.sv
rtl/vdfs_ctrl.sv
rtl/voxel_distance_fusion_store.sv
tb/sv/voxel_distance_fusion_store_tb.sv
